// ----- hdl/prf_pkg.sv -----
// Package for the packet rule filter: sizes, protocol constants, rule word codes,
// the item token that travels along the cell chain and the control state type.
// It depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package prf_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int IDX_W      = 4;
    localparam int CMP_W      = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [14:0] ETH_HDR_LEN = 15'd14;
    localparam logic [14:0] IP_HDR_LEN  = 15'd20;
    localparam logic [14:0] TCP_HDR_LEN = 15'd20;
    localparam logic [14:0] UDP_HDR_LEN = 15'd8;

    localparam logic REQ_CLASSIFY = 1'b0;
    localparam logic REQ_WRITE    = 1'b1;

    localparam logic [2:0] WSEL_ADDR_MASK = 3'd0;
    localparam logic [2:0] WSEL_FLAGS     = 3'd1;
    localparam logic [2:0] WSEL_IP        = 3'd2;
    localparam logic [2:0] WSEL_TCP       = 3'd3;
    localparam logic [2:0] WSEL_UDP       = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } prf_state_t;

    typedef struct packed {
        logic              is_write;
        logic [IDX_W-1:0]  rule_index;
        logic [2:0]        word_select;
        logic [63:0]       word_value;
        logic [31:0]       src;
        logic [31:0]       dst;
        logic [7:0]        proto;
        logic [7:0]        ttl;
        logic [15:0]       ipck;
        logic [15:0]       sp;
        logic [15:0]       dp;
        logic [15:0]       tck;
        logic              is_tcp;
        logic              done;
        logic              drop;
        logic              counted;
    } prf_tok_t;

endpackage

// ----- hdl/packet_rule_filter_top.sv -----
// Flow: an accepted item walks the chain of rule cells, one cell per cycle, and only one
// item is in the chain at a time; in_stall holds off new items while a scan runs or the
// skid stage holds a result.
// Reset: rst_n clears every rule slot, the drop counter and all control state at once.
// Top level of the packet rule filter; depends on prf_pkg and prf_cell.
`timescale 1ns / 1ps

module packet_rule_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  rule_index,
    input  logic [2:0]  word_select,
    input  logic [63:0] word_value,
    input  logic [13:0] frame_len,
    input  logic [15:0] ether_type,
    input  logic [35:0] ip_info,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] l4_src_port,
    input  logic [15:0] l4_dst_port,
    input  logic [15:0] tcp_checksum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        verdict,
    output logic [63:0] drop_total
);

    prf_pkg::prf_state_t state_reg;
    prf_pkg::prf_state_t state_next;

    logic [prf_pkg::RULE_SLOTS:0] tok_v;
    prf_pkg::prf_tok_t            tok_d [0:prf_pkg::RULE_SLOTS];

    logic              head_valid_reg;
    prf_pkg::prf_tok_t head_reg;
    prf_pkg::prf_tok_t head_next;

    logic        accept;
    logic        out_take;
    logic        scan_done;
    logic        res_verdict;
    logic [63:0] counter_reg;
    logic [63:0] counter_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        verdict_reg;
    logic        verdict_next;
    logic [63:0] total_reg;
    logic [63:0] total_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        skid_verdict_reg;
    logic        skid_verdict_next;
    logic [63:0] skid_total_reg;
    logic [63:0] skid_total_next;

    logic [14:0] len_ext;
    logic [7:0]  proto;
    logic        is_udp;
    logic        is_tcp;
    logic        udp_long;
    logic        tcp_long;
    logic        early_pass;

    assign in_stall = (state_reg != prf_pkg::ST_IDLE) || skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    assign len_ext  = {1'b0, frame_len};
    assign proto    = ip_info[23:16];
    assign is_udp   = (proto == prf_pkg::PROTO_UDP);
    assign is_tcp   = (proto == prf_pkg::PROTO_TCP);
    assign udp_long = (prf_pkg::ETH_HDR_LEN + prf_pkg::IP_HDR_LEN + prf_pkg::UDP_HDR_LEN)
        < len_ext;
    assign tcp_long = (prf_pkg::ETH_HDR_LEN + {9'd0, ip_info[35:32], 2'b00}
        + prf_pkg::TCP_HDR_LEN) <= len_ext;
    assign early_pass = (len_ext < prf_pkg::ETH_HDR_LEN + prf_pkg::IP_HDR_LEN)
        || (ether_type != prf_pkg::ETHERTYPE_IPV4)
        || !((is_udp && udp_long) || (is_tcp && tcp_long));

    always_comb
    begin
        head_next.is_write    = req_type;
        head_next.rule_index  = rule_index;
        head_next.word_select = word_select;
        head_next.word_value  = word_value;
        head_next.src         = src_addr;
        head_next.dst         = dst_addr;
        head_next.proto       = proto;
        head_next.ttl         = ip_info[31:24];
        head_next.ipck        = ip_info[15:0];
        head_next.sp          = l4_src_port;
        head_next.dp          = l4_dst_port;
        head_next.tck         = tcp_checksum;
        head_next.is_tcp      = is_tcp;
        head_next.done        = (req_type == prf_pkg::REQ_WRITE) || early_pass;
        head_next.drop        = 1'b0;
        head_next.counted     = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg <= head_next;
        end
    end

    assign tok_v[0] = head_valid_reg;
    assign tok_d[0] = head_reg;

    for (genvar g = 0; g < prf_pkg::RULE_SLOTS; g++)
    begin : g_cell
        prf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_id  ((prf_pkg::SLOT_W)'(g)),
            .up_valid (tok_v[g]),
            .up_tok   (tok_d[g]),
            .dn_valid (tok_v[g+1]),
            .dn_tok   (tok_d[g+1])
        );
    end

    assign scan_done   = tok_v[prf_pkg::RULE_SLOTS];
    assign res_verdict = (tok_d[prf_pkg::RULE_SLOTS].is_write == prf_pkg::REQ_CLASSIFY)
        && tok_d[prf_pkg::RULE_SLOTS].drop;
    assign counter_next = (scan_done && res_verdict && tok_d[prf_pkg::RULE_SLOTS].counted)
        ? counter_reg + 64'd1 : counter_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = prf_pkg::ST_SCAN;
                end
            end
            prf_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = prf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        verdict_next      = verdict_reg;
        total_next        = total_reg;
        skid_valid_next   = skid_valid_reg;
        skid_verdict_next = skid_verdict_reg;
        skid_total_next   = skid_total_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                verdict_next    = skid_verdict_reg;
                total_next      = skid_total_reg;
                skid_valid_next = 1'b0;
            end
            else if (scan_done)
            begin
                out_valid_next = 1'b1;
                verdict_next   = res_verdict;
                total_next     = counter_next;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (scan_done)
        begin
            skid_valid_next   = 1'b1;
            skid_verdict_next = res_verdict;
            skid_total_next   = counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prf_pkg::ST_IDLE;
            counter_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg      <= verdict_next;
        total_reg        <= total_next;
        skid_verdict_reg <= skid_verdict_next;
        skid_total_reg   <= skid_total_next;
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign drop_total = total_reg;

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_v))
        else $error("more than one item in the cell chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prf_pkg::ST_IDLE) |-> (tok_v == '0))
        else $error("item in the chain while the control is idle");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output is empty");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        (counter_reg == $past(counter_reg)) || (counter_reg == $past(counter_reg) + 64'd1))
        else $error("drop counter moved by more than one");
`endif

endmodule

// ----- hdl/prf_cell.sv -----
// One rule slot of the filter chain: holds the slot's rule words and checks or
// updates the item token passing through it, registering the token for the next cell.
// Depends on prf_pkg.
`timescale 1ns / 1ps

module prf_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [prf_pkg::SLOT_W-1:0]  slot_id,
    input  logic                        up_valid,
    input  prf_pkg::prf_tok_t           up_tok,
    output logic                        dn_valid,
    output prf_pkg::prf_tok_t           dn_tok
);

    logic [63:0]       addr_mask_reg;
    logic [2:0]        flags_reg;
    logic [63:0]       ip_fields_reg;
    logic [47:0]       tcp_fields_reg;
    logic [31:0]       udp_fields_reg;
    logic              tok_valid_reg;
    prf_pkg::prf_tok_t tok_reg;
    prf_pkg::prf_tok_t tok_next;

    logic        wr_hit;
    logic [31:0] rule_addr;
    logic [31:0] rule_mask;
    logic        addr_match;
    logic        ip_hit;
    logic        tcp_hit;
    logic        udp_hit;

    assign wr_hit = up_valid && (up_tok.is_write == prf_pkg::REQ_WRITE)
        && ((prf_pkg::CMP_W)'(up_tok.rule_index) == (prf_pkg::CMP_W)'(slot_id));

    assign rule_addr  = addr_mask_reg[31:0];
    assign rule_mask  = addr_mask_reg[63:32];
    assign addr_match = ((up_tok.src & rule_mask) == rule_addr);

    assign ip_hit = flags_reg[0] && (
        (ip_fields_reg[7:0] == up_tok.proto) ||
        (ip_fields_reg[23:8] == up_tok.ipck) ||
        (ip_fields_reg[31:24] == up_tok.ttl) ||
        (ip_fields_reg[63:32] == up_tok.dst));

    assign tcp_hit = up_tok.is_tcp && flags_reg[1] && (
        (tcp_fields_reg[15:0] == up_tok.sp) ||
        (tcp_fields_reg[31:16] == up_tok.dp) ||
        (tcp_fields_reg[47:32] == up_tok.tck));

    assign udp_hit = !up_tok.is_tcp && flags_reg[2] && (
        (udp_fields_reg[15:0] == up_tok.sp) ||
        (udp_fields_reg[31:16] == up_tok.dp));

    always_comb
    begin
        tok_next = up_tok;
        if ((up_tok.is_write == prf_pkg::REQ_CLASSIFY) && !up_tok.done)
        begin
            if (rule_addr == 32'd0)
            begin
                tok_next.done = 1'b1;
            end
            else if (addr_match)
            begin
                if (flags_reg == 3'd0 || ip_hit || tcp_hit)
                begin
                    tok_next.done    = 1'b1;
                    tok_next.drop    = 1'b1;
                    tok_next.counted = 1'b1;
                end
                else if (udp_hit)
                begin
                    tok_next.done    = 1'b1;
                    tok_next.drop    = 1'b1;
                    tok_next.counted = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_mask_reg  <= '0;
            flags_reg      <= '0;
            ip_fields_reg  <= '0;
            tcp_fields_reg <= '0;
            udp_fields_reg <= '0;
            tok_valid_reg  <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= up_valid;
            if (wr_hit)
            begin
                case (up_tok.word_select)
                    prf_pkg::WSEL_ADDR_MASK: addr_mask_reg  <= up_tok.word_value;
                    prf_pkg::WSEL_FLAGS:     flags_reg      <= up_tok.word_value[2:0];
                    prf_pkg::WSEL_IP:        ip_fields_reg  <= up_tok.word_value;
                    prf_pkg::WSEL_TCP:       tcp_fields_reg <= up_tok.word_value[47:0];
                    prf_pkg::WSEL_UDP:       udp_fields_reg <= up_tok.word_value[31:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign dn_valid = tok_valid_reg;
    assign dn_tok   = tok_reg;

endmodule

// ----- tb/packet_rule_filter_top_tb.sv -----
// Self-checking testbench for packet_rule_filter_top: a directed table, then rule-table fills
// and random packets under several idle and stall patterns; results are predicted or fixed.
// Depends on prf_pkg and the packet_rule_filter_top RTL.
`timescale 1ns / 1ps

module packet_rule_filter_top_tb;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         PHASE_ITEMS    = 308;
    localparam int         CHECK_IP_BIT   = 0;
    localparam int         CHECK_TCP_BIT  = 1;
    localparam int         CHECK_UDP_BIT  = 2;
    localparam logic [2:0] WSEL_UNUSED    = 3'd7;
    localparam logic [7:0] PROTO_ICMP     = 8'd1;

    typedef enum logic [1:0] {
        FLT_PASS,
        FLT_DROP_COUNTED,
        FLT_DROP_UNCOUNTED
    } filter_outcome_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  rule_index;
        logic [2:0]  word_select;
        logic [63:0] word_value;
        logic [13:0] frame_len;
        logic [15:0] ether_type;
        logic [35:0] ip_info;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_src_port;
        logic [15:0] l4_dst_port;
        logic [15:0] tcp_checksum;
    } filter_req_t;

    typedef struct packed {
        logic        verdict;
        logic [63:0] drop_total;
    } filter_result_t;

    typedef struct {
        filter_req_t    req;
        bit             fixed;
        filter_result_t result;
    } directed_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        req_type     = 1'b0;
    logic [3:0]  rule_index   = '0;
    logic [2:0]  word_select  = '0;
    logic [63:0] word_value   = '0;
    logic [13:0] frame_len    = '0;
    logic [15:0] ether_type   = '0;
    logic [35:0] ip_info      = '0;
    logic [31:0] src_addr     = '0;
    logic [31:0] dst_addr     = '0;
    logic [15:0] l4_src_port  = '0;
    logic [15:0] l4_dst_port  = '0;
    logic [15:0] tcp_checksum = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        verdict;
    logic [63:0] drop_total;

    logic [63:0] addr_mask_rules [prf_pkg::RULE_SLOTS];
    logic [2:0]  check_flags     [prf_pkg::RULE_SLOTS];
    logic [63:0] ip_words        [prf_pkg::RULE_SLOTS];
    logic [47:0] tcp_words       [prf_pkg::RULE_SLOTS];
    logic [31:0] udp_words       [prf_pkg::RULE_SLOTS];
    logic [63:0] drops_counted;
    logic [31:0] prefix_bases    [4];

    filter_result_t awaited_results [$];
    int             errors       = 0;
    int             idle_pct     = 0;
    int             stall_pct    = 0;
    int             quiet_cycles = 0;

    packet_rule_filter_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .rule_index   (rule_index),
        .word_select  (word_select),
        .word_value   (word_value),
        .frame_len    (frame_len),
        .ether_type   (ether_type),
        .ip_info      (ip_info),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .l4_src_port  (l4_src_port),
        .l4_dst_port  (l4_dst_port),
        .tcp_checksum (tcp_checksum),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict      (verdict),
        .drop_total   (drop_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic filter_outcome_t classify_packet(input filter_req_t r);
        int              len;
        int              ihl;
        int              i;
        logic [7:0]      ttl;
        logic [7:0]      proto;
        logic [15:0]     ipck;
        logic [31:0]     addr;
        logic [31:0]     mask;
        logic            is_tcp;
        bit              scanning;
        filter_outcome_t outcome;
        len      = int'(r.frame_len);
        ihl      = int'(r.ip_info[35:32]);
        ttl      = r.ip_info[31:24];
        proto    = r.ip_info[23:16];
        ipck     = r.ip_info[15:0];
        is_tcp   = 1'b0;
        outcome  = FLT_PASS;
        scanning = 1'b0;
        if (len >= int'(prf_pkg::ETH_HDR_LEN) && r.ether_type == prf_pkg::ETHERTYPE_IPV4
            && len >= int'(prf_pkg::ETH_HDR_LEN + prf_pkg::IP_HDR_LEN))
        begin
            if (proto == prf_pkg::PROTO_UDP)
            begin
                scanning = len > int'(prf_pkg::ETH_HDR_LEN + prf_pkg::IP_HDR_LEN
                                      + prf_pkg::UDP_HDR_LEN);
            end
            else if (proto == prf_pkg::PROTO_TCP)
            begin
                is_tcp   = 1'b1;
                scanning = int'(prf_pkg::ETH_HDR_LEN) + 4 * ihl
                           + int'(prf_pkg::TCP_HDR_LEN) <= len;
            end
        end
        for (i = 0; i < prf_pkg::RULE_SLOTS && scanning; i++)
        begin
            addr = addr_mask_rules[i][31:0];
            mask = addr_mask_rules[i][63:32];
            if (addr == 32'd0)
            begin
                scanning = 1'b0;
            end
            else if ((r.src_addr & mask) == addr)
            begin
                if (check_flags[i] == 3'd0)
                begin
                    outcome = FLT_DROP_COUNTED;
                end
                else if (check_flags[i][CHECK_IP_BIT]
                    && (ip_words[i][7:0] == proto || ip_words[i][23:8] == ipck
                        || ip_words[i][31:24] == ttl || ip_words[i][63:32] == r.dst_addr))
                begin
                    outcome = FLT_DROP_COUNTED;
                end
                else if (is_tcp && check_flags[i][CHECK_TCP_BIT]
                    && (tcp_words[i][15:0] == r.l4_src_port
                        || tcp_words[i][31:16] == r.l4_dst_port
                        || tcp_words[i][47:32] == r.tcp_checksum))
                begin
                    outcome = FLT_DROP_COUNTED;
                end
                else if (!is_tcp && check_flags[i][CHECK_UDP_BIT]
                    && (udp_words[i][15:0] == r.l4_src_port
                        || udp_words[i][31:16] == r.l4_dst_port))
                begin
                    outcome = FLT_DROP_UNCOUNTED;
                end
                if (outcome != FLT_PASS)
                begin
                    scanning = 1'b0;
                end
            end
        end
        return outcome;
    endfunction

    function automatic filter_result_t judge_item(input filter_req_t r);
        filter_result_t  res;
        filter_outcome_t outcome;
        res.verdict = 1'b0;
        if (r.req_type == prf_pkg::REQ_WRITE)
        begin
            if (int'(r.rule_index) < prf_pkg::RULE_SLOTS)
            begin
                case (r.word_select)
                    prf_pkg::WSEL_ADDR_MASK: addr_mask_rules[r.rule_index] = r.word_value;
                    prf_pkg::WSEL_FLAGS:     check_flags[r.rule_index] = r.word_value[2:0];
                    prf_pkg::WSEL_IP:        ip_words[r.rule_index] = r.word_value;
                    prf_pkg::WSEL_TCP:       tcp_words[r.rule_index] = r.word_value[47:0];
                    prf_pkg::WSEL_UDP:       udp_words[r.rule_index] = r.word_value[31:0];
                    default:                 ;
                endcase
            end
        end
        else
        begin
            outcome = classify_packet(r);
            if (outcome == FLT_DROP_COUNTED)
            begin
                drops_counted = drops_counted + 64'd1;
            end
            res.verdict = (outcome != FLT_PASS);
        end
        res.drop_total = drops_counted;
        return res;
    endfunction

    function automatic filter_req_t random_noise();
        filter_req_t r;
        r.req_type     = prf_pkg::REQ_CLASSIFY;
        r.rule_index   = 4'($urandom);
        r.word_select  = 3'($urandom);
        r.word_value   = {$urandom, $urandom};
        r.frame_len    = 14'($urandom);
        r.ether_type   = 16'($urandom);
        r.ip_info      = {4'($urandom), 32'($urandom)};
        r.src_addr     = $urandom;
        r.dst_addr     = $urandom;
        r.l4_src_port  = 16'($urandom);
        r.l4_dst_port  = 16'($urandom);
        r.tcp_checksum = 16'($urandom);
        return r;
    endfunction

    function automatic filter_req_t rule_write(input logic [3:0] idx, input logic [2:0] sel,
                                               input logic [63:0] val);
        filter_req_t r;
        r             = random_noise();
        r.req_type    = prf_pkg::REQ_WRITE;
        r.rule_index  = idx;
        r.word_select = sel;
        r.word_value  = val;
        return r;
    endfunction

    function automatic filter_req_t make_packet(input logic [13:0] len, input logic [15:0] etype,
                                                input logic [35:0] info, input logic [31:0] src,
                                                input logic [31:0] dst, input logic [15:0] sp,
                                                input logic [15:0] dp, input logic [15:0] tck);
        filter_req_t r;
        r              = random_noise();
        r.req_type     = prf_pkg::REQ_CLASSIFY;
        r.frame_len    = len;
        r.ether_type   = etype;
        r.ip_info      = info;
        r.src_addr     = src;
        r.dst_addr     = dst;
        r.l4_src_port  = sp;
        r.l4_dst_port  = dp;
        r.tcp_checksum = tck;
        return r;
    endfunction

    function automatic directed_row_t dir_row(input filter_req_t r, input bit fixed,
                                              input logic v, input logic [63:0] total);
        directed_row_t row;
        row.req                = r;
        row.fixed              = fixed;
        row.result.verdict     = v;
        row.result.drop_total  = total;
        return row;
    endfunction

    function automatic logic [63:0] random_addr_mask();
        int unsigned plen;
        logic [31:0] base;
        logic [31:0] mask;
        logic [31:0] addr;
        base = prefix_bases[$urandom_range(3)];
        if ($urandom_range(9) == 0)
        begin
            mask = $urandom;
        end
        else
        begin
            plen = $urandom_range(32, 8);
            mask = 32'hFFFF_FFFF << (32 - plen);
        end
        addr = base & mask;
        if (addr == 32'd0)
        begin
            addr = base;
        end
        return {mask, addr};
    endfunction

    function automatic filter_req_t random_packet();
        filter_req_t r;
        int unsigned pick;
        int unsigned slot;
        int unsigned donor;
        logic [3:0]  ihl;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [15:0] ipck;
        r = random_noise();
        if ($urandom_range(99) < 92)
        begin
            r.ether_type = prf_pkg::ETHERTYPE_IPV4;
        end
        pick  = $urandom_range(99);
        proto = (pick < 45) ? prf_pkg::PROTO_TCP
              : (pick < 90) ? prf_pkg::PROTO_UDP : 8'($urandom);
        ihl   = ($urandom_range(1) == 0) ? 4'd5 : 4'($urandom);
        ttl   = 8'($urandom);
        ipck  = 16'($urandom);
        pick  = $urandom_range(99);
        if (pick < 15)
        begin
            r.frame_len = 14'($urandom_range(100));
        end
        else if (pick < 85)
        begin
            r.frame_len = 14'($urandom_range(1514, 34));
        end
        slot = $urandom_range(prf_pkg::RULE_SLOTS - 1);
        if (addr_mask_rules[slot][31:0] == 32'd0)
        begin
            slot = 0;
        end
        if ($urandom_range(3) != 0)
        begin
            r.src_addr = addr_mask_rules[slot][31:0]
                       | ($urandom & ~addr_mask_rules[slot][63:32]);
        end
        donor = $urandom_range(prf_pkg::RULE_SLOTS - 1);
        if ($urandom_range(7) == 0)
        begin
            ttl = ip_words[donor][31:24];
        end
        if ($urandom_range(7) == 0)
        begin
            ipck = ip_words[donor][23:8];
        end
        if ($urandom_range(7) == 0)
        begin
            r.dst_addr = ip_words[donor][63:32];
        end
        if ($urandom_range(7) == 0)
        begin
            r.l4_src_port = (proto == prf_pkg::PROTO_UDP) ? udp_words[donor][15:0]
                                                          : tcp_words[donor][15:0];
        end
        if ($urandom_range(7) == 0)
        begin
            r.l4_dst_port = (proto == prf_pkg::PROTO_UDP) ? udp_words[donor][31:16]
                                                          : tcp_words[donor][31:16];
        end
        if ($urandom_range(7) == 0)
        begin
            r.tcp_checksum = tcp_words[donor][47:32];
        end
        r.ip_info = {ihl, ttl, proto, ipck};
        return r;
    endfunction

    function automatic filter_req_t random_item();
        logic [3:0]  idx;
        logic [2:0]  sel;
        logic [63:0] val;
        int unsigned pick;
        if ($urandom_range(99) >= 12)
        begin
            return random_packet();
        end
        idx = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
        sel = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        val = {$urandom, $urandom};
        if (sel == prf_pkg::WSEL_ADDR_MASK)
        begin
            pick = $urandom_range(19);
            if (pick == 1)
            begin
                val[31:0] = 32'd0;
            end
            else if (pick > 1)
            begin
                val = random_addr_mask();
            end
        end
        return rule_write(idx, sel, val);
    endfunction

    task automatic send_item(input filter_req_t r, input bit fixed,
                             input filter_result_t fixed_result);
        filter_result_t predicted;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= r.req_type;
        rule_index   <= r.rule_index;
        word_select  <= r.word_select;
        word_value   <= r.word_value;
        frame_len    <= r.frame_len;
        ether_type   <= r.ether_type;
        ip_info      <= r.ip_info;
        src_addr     <= r.src_addr;
        dst_addr     <= r.dst_addr;
        l4_src_port  <= r.l4_src_port;
        l4_dst_port  <= r.l4_dst_port;
        tcp_checksum <= r.tcp_checksum;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = judge_item(r);
        awaited_results.push_back(fixed ? fixed_result : predicted);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0);
    endtask

    task automatic fill_rule_table();
        int          slot;
        logic [63:0] flags;
        for (slot = 0; slot < prf_pkg::RULE_SLOTS; slot++)
        begin
            flags = {$urandom, $urandom};
            if ($urandom_range(7) == 0)
            begin
                flags[2:0] = 3'd0;
            end
            else if (flags[2:0] == 3'd0)
            begin
                flags[CHECK_IP_BIT] = 1'b1;
            end
            send_item(rule_write(4'(slot), prf_pkg::WSEL_ADDR_MASK, random_addr_mask()),
                      1'b0, '0);
            send_item(rule_write(4'(slot), prf_pkg::WSEL_FLAGS, flags), 1'b0, '0);
            send_item(rule_write(4'(slot), prf_pkg::WSEL_IP, {$urandom, $urandom}), 1'b0, '0);
            send_item(rule_write(4'(slot), prf_pkg::WSEL_TCP, {$urandom, $urandom}), 1'b0, '0);
            send_item(rule_write(4'(slot), prf_pkg::WSEL_UDP, {$urandom, $urandom}), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got verdict %0b drop_total %0d",
                         $time, verdict, drop_total);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (verdict !== want.verdict)
                begin
                    $display("%0t: verdict expected %0b, got %0b", $time, want.verdict, verdict);
                    errors++;
                end
                if (drop_total !== want.drop_total)
                begin
                    $display("%0t: drop_total expected %0d, got %0d",
                             $time, want.drop_total, drop_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("packet_rule_filter_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        directed_row_t rows [$];
        int            n;
        int            phase;
        for (n = 0; n < prf_pkg::RULE_SLOTS; n++)
        begin
            addr_mask_rules[n] = '0;
            check_flags[n]     = '0;
            ip_words[n]        = '0;
            tcp_words[n]       = '0;
            udp_words[n]       = '0;
        end
        drops_counted = '0;
        for (n = 0; n < 4; n++)
        begin
            prefix_bases[n] = {8'($urandom_range(255, 1)), 24'($urandom)};
        end

        rows.push_back(dir_row(make_packet(14'd0, 16'h0000, 36'd0, 32'd0, 32'd0, 16'd0, 16'd0,
                                           16'd0), 1'b1, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet('1, '1, '1, '1, '1, '1, '1, '1), 1'b1, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b0, 64'd0));
        rows.push_back(dir_row(rule_write(4'd15, WSEL_UNUSED, '1), 1'b1, 1'b0, 64'd0));
        rows.push_back(dir_row(rule_write(4'd0, prf_pkg::WSEL_ADDR_MASK,
                                          {32'hFF00_0000, 32'h0A00_0000}),
                               1'b1, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b1, 64'd1));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_UDP, 16'h0},
                                           32'h0A00_00FF, 32'h0, 16'd53, 16'd53, 16'h0),
                               1'b1, 1'b1, 64'd2));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0B01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b0, 64'd2));
        rows.push_back(dir_row(make_packet(14'd33, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b0, 64'd2));
        rows.push_back(dir_row(make_packet(14'd42, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_UDP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd53, 16'd53, 16'h0),
                               1'b1, 1'b0, 64'd2));
        rows.push_back(dir_row(make_packet(14'd43, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_UDP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd53, 16'd53, 16'h0),
                               1'b1, 1'b1, 64'd3));
        rows.push_back(dir_row(make_packet(14'd93, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd15, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b0, 64'd3));
        rows.push_back(dir_row(make_packet(14'd94, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd15, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b1, 64'd4));
        rows.push_back(dir_row(make_packet(14'd34, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd0, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0AFF_FFFF, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b1, 64'd5));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, PROTO_ICMP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd0, 16'd0, 16'h0),
                               1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(make_packet(14'd13, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h0},
                                           32'h0A01_0203, 32'h0, 16'd80, 16'd443, 16'h0),
                               1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(rule_write(4'd0, prf_pkg::WSEL_FLAGS, '1), 1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(rule_write(4'd0, prf_pkg::WSEL_IP,
                                          {32'hC0A8_0001, 8'h40, 16'h1234, 8'h55}),
                               1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(rule_write(4'd0, prf_pkg::WSEL_TCP, '1), 1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(rule_write(4'd0, prf_pkg::WSEL_UDP,
                                          {32'hFFFF_FFFF, 16'h1111, 16'h0035}),
                               1'b1, 1'b0, 64'd5));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h41, prf_pkg::PROTO_TCP, 16'h1235},
                                           32'h0A01_0203, 32'hC0A8_0002, 16'd80, 16'd443, 16'h0),
                               1'b0, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h41, prf_pkg::PROTO_TCP, 16'h1235},
                                           32'h0A01_0203, 32'hC0A8_0001, 16'd80, 16'd443, 16'h0),
                               1'b0, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h41, prf_pkg::PROTO_TCP, 16'h1235},
                                           32'h0A01_0203, 32'hC0A8_0002, 16'd80, 16'd443,
                                           16'hFFFF),
                               1'b0, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h41, prf_pkg::PROTO_UDP, 16'h1235},
                                           32'h0A01_0203, 32'hC0A8_0002, 16'd80, 16'h1111,
                                           16'h0),
                               1'b0, 1'b0, 64'd0));
        rows.push_back(dir_row(make_packet(14'd1514, prf_pkg::ETHERTYPE_IPV4,
                                           {4'd5, 8'h40, prf_pkg::PROTO_TCP, 16'h1235},
                                           32'h0A01_0203, 32'hC0A8_0002, 16'd80, 16'd443, 16'h0),
                               1'b0, 1'b0, 64'd0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[row_i])
        begin
            send_item(rows[row_i].req, rows[row_i].fixed, rows[row_i].result);
        end

        for (phase = 0; phase < 4; phase++)
        begin
            wait_for_results();
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    idle_pct  = 31;
                    stall_pct = 31;
                end
            endcase
            fill_rule_table();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("packet_rule_filter_top_tb OK");
        end
        else
        begin
            $display("packet_rule_filter_top_tb NOT OK");
        end
        $finish;
    end

endmodule
